// ----- rtl/core/assert_macros.svh -----
// Assertion helpers; the using module supplies clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TKD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define TKD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/tkd_pkg.sv -----
`default_nettype none
package tkd_pkg;

	localparam int LEAD_SLOTS_DEF = 4;
	localparam int LEAD_SLOTS_MAX = 8;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEAD_BYTES,
		REG_LEAD_COUNT,
		REG_GAP_MS,
		REG_MAX_LEN
	} reg_idx_t;

	localparam logic [31:0] LEAD_BYTES_RST = 32'd27;
	localparam logic [2:0]  LEAD_COUNT_RST = 3'd1;
	localparam logic [7:0]  GAP_MS_RST     = 8'd50;
	localparam logic [3:0]  MAX_LEN_RST    = 4'd5;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEAD,
		PH_SS3,
		PH_CSI,
		PH_DRAIN
	} phase_t;

	typedef enum logic [2:0] {
		KIND_PLAIN,
		KIND_BARE,
		KIND_ALT,
		KIND_KEY,
		KIND_UNKNOWN,
		KIND_OVERFLOW
	} kind_t;

	localparam logic [4:0] KEY_UP     = 5'd0;
	localparam logic [4:0] KEY_DOWN   = 5'd1;
	localparam logic [4:0] KEY_RIGHT  = 5'd2;
	localparam logic [4:0] KEY_LEFT   = 5'd3;
	localparam logic [4:0] KEY_HOME   = 5'd4;
	localparam logic [4:0] KEY_END    = 5'd5;
	localparam logic [4:0] KEY_INSERT = 5'd6;
	localparam logic [4:0] KEY_DELETE = 5'd7;
	localparam logic [4:0] KEY_PGUP   = 5'd8;
	localparam logic [4:0] KEY_PGDN   = 5'd9;
	localparam logic [4:0] KEY_F1     = 5'd10;
	localparam logic [4:0] KEY_F2     = 5'd11;
	localparam logic [4:0] KEY_F3     = 5'd12;
	localparam logic [4:0] KEY_F4     = 5'd13;
	localparam logic [4:0] KEY_F5     = 5'd14;
	localparam logic [4:0] KEY_F6     = 5'd15;
	localparam logic [4:0] KEY_F7     = 5'd16;
	localparam logic [4:0] KEY_F8     = 5'd17;
	localparam logic [4:0] KEY_F9     = 5'd18;
	localparam logic [4:0] KEY_F10    = 5'd19;
	localparam logic [4:0] KEY_F11    = 5'd20;
	localparam logic [4:0] KEY_F12    = 5'd21;

	localparam logic [7:0] CH_CSI   = 8'h5B;
	localparam logic [7:0] CH_SS3   = 8'h4F;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] FINAL_LO = 8'h40;
	localparam logic [7:0] FINAL_HI = 8'h7E;

	typedef struct packed {
		logic [31:0] lead_bytes;
		logic [2:0]  lead_count;
		logic [7:0]  gap_ms;
		logic [3:0]  max_len;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		kind_t      kind;
		logic [7:0] char_value;
		logic [4:0] key_code;
	} result_t;

endpackage
`default_nettype wire

// ----- rtl/core/tkd_key_match.sv -----
`default_nettype none
module tkd_key_match (
	input  wire logic       ss3,
	input  wire logic [7:0] param,
	input  wire logic [7:0] fin,
	output logic      [4:0] key_code,
	output logic            hit
);
	import tkd_pkg::*;

	logic [4:0] cur_key;
	logic       cur_hit;

	always_comb begin
		cur_hit = 1'b1;
		case (fin)
			"A":     cur_key = KEY_UP;
			"B":     cur_key = KEY_DOWN;
			"C":     cur_key = KEY_RIGHT;
			"D":     cur_key = KEY_LEFT;
			"H":     cur_key = KEY_HOME;
			"F":     cur_key = KEY_END;
			default: begin
				cur_key = KEY_UP;
				cur_hit = 1'b0;
			end
		endcase
	end

	always_comb begin
		key_code = cur_key;
		hit      = cur_hit;
		if (ss3) begin
			case (fin)
				"P":     key_code = KEY_F1;
				"Q":     key_code = KEY_F2;
				"R":     key_code = KEY_F3;
				"S":     key_code = KEY_F4;
				default: key_code = cur_key;
			endcase
			if (fin == "P" || fin == "Q" || fin == "R" || fin == "S")
				hit = 1'b1;
		end else if (fin != CH_TILDE) begin
			hit = cur_hit && (param == 8'd0);
		end else begin
			hit = 1'b1;
			case (param)
				8'd1:    key_code = KEY_HOME;
				8'd2:    key_code = KEY_INSERT;
				8'd3:    key_code = KEY_DELETE;
				8'd4:    key_code = KEY_END;
				8'd5:    key_code = KEY_PGUP;
				8'd6:    key_code = KEY_PGDN;
				8'd7:    key_code = KEY_HOME;
				8'd8:    key_code = KEY_END;
				8'd15:   key_code = KEY_F5;
				8'd17:   key_code = KEY_F6;
				8'd18:   key_code = KEY_F7;
				8'd19:   key_code = KEY_F8;
				8'd20:   key_code = KEY_F9;
				8'd21:   key_code = KEY_F10;
				8'd23:   key_code = KEY_F11;
				8'd24:   key_code = KEY_F12;
				default: begin
					key_code = KEY_UP;
					hit      = 1'b0;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/tkd_fsm.sv -----
`default_nettype none
`include "assert_macros.svh"
module tkd_fsm #(
	parameter int LEAD_SLOTS = tkd_pkg::LEAD_SLOTS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step,
	input  wire logic           cmd,
	input  wire logic     [7:0] rx_byte,
	input  wire tkd_pkg::cfg_t  cfg,
	output tkd_pkg::result_t    res
);
	import tkd_pkg::*;

	phase_t     phase_q, phase_d;
	logic [7:0] held_lead_q, held_lead_d;
	logic [7:0] param_q, param_d;
	logic       param_seen_q, param_seen_d;
	logic       mod_seen_q, mod_seen_d;
	logic [3:0] byte_cnt_q, byte_cnt_d;
	logic [7:0] gap_q, gap_d;

	logic [8*LEAD_SLOTS_MAX-1:0] lead_ext;
	logic       lead_hit;
	logic [7:0] gap_inc;
	logic       gap_end;
	logic       is_digit;
	logic       is_final;
	logic       csi_full;
	logic [7:0] param_mac;
	logic [4:0] key_code;
	logic       key_hit;

	assign lead_ext = {{(8*LEAD_SLOTS_MAX-32){1'b0}}, cfg.lead_bytes};

	always_comb begin
		lead_hit = 1'b0;
		for (int i = 0; i < LEAD_SLOTS; i++) begin
			if (4'(i) < {1'b0, cfg.lead_count} && lead_ext[8*i +: 8] == rx_byte)
				lead_hit = 1'b1;
		end
	end

	assign gap_inc   = (gap_q == 8'hFF) ? gap_q : gap_q + 8'd1;
	assign gap_end   = gap_inc >= cfg.gap_ms;
	assign is_digit  = rx_byte >= CH_ZERO && rx_byte <= CH_NINE;
	assign is_final  = rx_byte >= FINAL_LO && rx_byte <= FINAL_HI;
	assign csi_full  = byte_cnt_q >= cfg.max_len;
	assign param_mac = {param_q[4:0], 3'b000} + {param_q[6:0], 1'b0} + (rx_byte - CH_ZERO);

	tkd_key_match u_match (
		.ss3      (phase_q == PH_SS3),
		.param    (param_seen_q ? param_q : 8'd0),
		.fin      (rx_byte),
		.key_code (key_code),
		.hit      (key_hit)
	);

	always_comb begin
		phase_d      = phase_q;
		held_lead_d  = held_lead_q;
		param_d      = param_q;
		param_seen_d = param_seen_q;
		mod_seen_d   = mod_seen_q;
		byte_cnt_d   = byte_cnt_q;
		gap_d        = gap_q;
		if (step && cmd) begin
			if (phase_q != PH_IDLE) begin
				gap_d = gap_inc;
				if (gap_end) begin
					phase_d = PH_IDLE;
					gap_d   = 8'd0;
				end
			end
		end else if (step && rx_byte != 8'd0) begin
			gap_d = 8'd0;
			case (phase_q)
				PH_LEAD: begin
					if (rx_byte == CH_CSI) begin
						phase_d      = PH_CSI;
						param_d      = 8'd0;
						param_seen_d = 1'b0;
						mod_seen_d   = 1'b0;
						byte_cnt_d   = 4'd0;
					end else if (rx_byte == CH_SS3) begin
						phase_d = PH_SS3;
					end else begin
						phase_d = PH_IDLE;
					end
				end
				PH_SS3: phase_d = PH_IDLE;
				PH_CSI: begin
					if (csi_full) begin
						phase_d = PH_DRAIN;
					end else begin
						byte_cnt_d = byte_cnt_q + 4'd1;
						if (is_digit) begin
							if (!mod_seen_q) begin
								param_d      = param_mac;
								param_seen_d = 1'b1;
							end
						end else if (rx_byte == CH_SEMI) begin
							mod_seen_d = 1'b1;
						end else if (is_final) begin
							phase_d = PH_IDLE;
						end
					end
				end
				PH_DRAIN: phase_d = PH_DRAIN;
				default: begin
					if (lead_hit) begin
						phase_d     = PH_LEAD;
						held_lead_d = rx_byte;
					end else begin
						phase_d = PH_IDLE;
					end
				end
			endcase
		end
	end

	always_comb begin
		res = '{valid: 1'b0, kind: KIND_PLAIN, char_value: 8'd0, key_code: 5'd0};
		if (step && cmd) begin
			if (phase_q != PH_IDLE && gap_end) begin
				res.valid = 1'b1;
				case (phase_q)
					PH_LEAD: begin
						res.kind       = KIND_BARE;
						res.char_value = held_lead_q;
					end
					PH_DRAIN: res.kind = KIND_OVERFLOW;
					default:  res.kind = KIND_UNKNOWN;
				endcase
			end
		end else if (step && rx_byte != 8'd0) begin
			case (phase_q)
				PH_LEAD: begin
					if (rx_byte != CH_CSI && rx_byte != CH_SS3) begin
						res.valid      = 1'b1;
						res.kind       = KIND_ALT;
						res.char_value = rx_byte;
					end
				end
				PH_SS3: begin
					res.valid    = 1'b1;
					res.kind     = key_hit ? KIND_KEY : KIND_UNKNOWN;
					res.key_code = key_hit ? key_code : 5'd0;
				end
				PH_CSI: begin
					if (!csi_full && !is_digit && rx_byte != CH_SEMI && is_final) begin
						res.valid    = 1'b1;
						res.kind     = key_hit ? KIND_KEY : KIND_UNKNOWN;
						res.key_code = key_hit ? key_code : 5'd0;
					end
				end
				PH_DRAIN: res.valid = 1'b0;
				default: begin
					if (!lead_hit) begin
						res.valid      = 1'b1;
						res.kind       = KIND_PLAIN;
						res.char_value = rx_byte;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			held_lead_q  <= 8'd0;
			param_q      <= 8'd0;
			param_seen_q <= 1'b0;
			mod_seen_q   <= 1'b0;
			byte_cnt_q   <= 4'd0;
			gap_q        <= 8'd0;
		end else begin
			phase_q      <= phase_d;
			held_lead_q  <= held_lead_d;
			param_q      <= param_d;
			param_seen_q <= param_seen_d;
			mod_seen_q   <= mod_seen_d;
			byte_cnt_q   <= byte_cnt_d;
			gap_q        <= gap_d;
		end
	end

	`TKD_ASSERT_IMP(a_idle_gap_clear, phase_q == PH_IDLE, gap_q == 8'd0, "gap count live in idle")
	`TKD_ASSERT_IMP(a_bare_from_lead, res.valid && res.kind == KIND_BARE, phase_q == PH_LEAD, "bare lead outside lead phase")

endmodule
`default_nettype wire

// ----- rtl/core/terminal_escape_key_decoder_top.sv -----
// Console key decoder: takes one request per cycle while s_tready is high (a received byte, or a
// 1 ms tick when s_tuser is high) and gives at most one result per request, offered on m_tvalid
// through the input register and then the result register. A new request is taken each cycle
// while the result register drains; a stalled result holds the input register and then s_tready.
// Bytes of zero are dropped.
// Registers written through cfg_we/cfg_index/cfg_data: 0 lead bytes (slot 0 in the low
// byte, reset ESC), 1 lead slots in use (reset 1), 2 gap in ticks (reset 50), 3 longest
// CSI body before overflow (reset 5). Write them only while no burst is in progress.
`default_nettype none
`include "assert_macros.svh"
module terminal_escape_key_decoder_top #(
	parameter int LEAD_SLOTS = tkd_pkg::LEAD_SLOTS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic                     [7:0] s_tdata,   // rx_byte
	input  wire logic                           s_tuser,   // cmd
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic                         [15:0] m_tdata,   // char_value, key_code, zero pad
	output logic                          [2:0] m_tuser,   // kind
	input  wire logic                           cfg_we,
	input  wire logic [tkd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tkd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tkd_pkg::*;

	cfg_t       cfg_q;
	logic       valid_s1;
	logic       cmd_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	kind_t      out_kind_q;
	logic [7:0] out_char_q;
	logic [4:0] out_key_q;
	logic       advance;
	result_t    res;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {3'b000, out_key_q, out_char_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{lead_bytes: LEAD_BYTES_RST, lead_count: LEAD_COUNT_RST,
				gap_ms: GAP_MS_RST, max_len: MAX_LEN_RST};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEAD_BYTES: cfg_q.lead_bytes <= cfg_data;
				REG_LEAD_COUNT: cfg_q.lead_count <= cfg_data[2:0];
				REG_GAP_MS:     cfg_q.gap_ms     <= cfg_data[7:0];
				REG_MAX_LEN:    cfg_q.max_len    <= cfg_data[3:0];
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance)
				out_valid_q <= valid_s1 && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= s_tuser;
			byte_s1 <= s_tdata;
		end
		if (advance && valid_s1 && res.valid) begin
			out_kind_q <= res.kind;
			out_char_q <= res.char_value;
			out_key_q  <= res.key_code;
		end
	end

	tkd_fsm #(
		.LEAD_SLOTS (LEAD_SLOTS)
	) u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (valid_s1 && advance),
		.cmd     (cmd_s1),
		.rx_byte (byte_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	`TKD_ASSERT_IMP(a_key_only_on_key, m_tvalid && m_tuser != KIND_KEY, m_tdata[12:8] == 5'd0, "key code set on non-key result")
	`TKD_ASSERT_NXT(a_hold_on_stall, valid_s1 && m_tvalid && !m_tready, valid_s1, "request lost under output stall")

endmodule
`default_nettype wire
